/* hdl/tct_pkg.sv */
// Shared types and codes for the touch contact tracker.
package tct_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FINGER_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THUMB_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALM_THR = 2'd2;

  localparam logic [2:0] KIND_DOWN = 3'd0;
  localparam logic [2:0] KIND_MOTION = 3'd1;
  localparam logic [2:0] KIND_PRESSURE = 3'd2;
  localparam logic [2:0] KIND_UP = 3'd3;
  localparam logic [2:0] KIND_CANCEL = 3'd4;

  localparam logic [1:0] TYPE_NONE = 2'd0;
  localparam logic [1:0] TYPE_FINGER = 2'd1;
  localparam logic [1:0] TYPE_THUMB = 2'd2;
  localparam logic [1:0] TYPE_PALM = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  contact_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] contact_pressure;
    logic [31:0] time_now;
  } tct_in_t;

  typedef struct packed {
    logic [3:0] slot_index;
    logic       hit;
    logic [1:0] contact_type;
    logic       contact_valid;
    logic       table_full;
  } tct_out_t;

endpackage

/* hdl/touch_contact_tracker.sv */
// Touch contact slot table: id and payload memories scanned per request.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | tct_in_t event request
//  out     | output    | out_valid/out_stall| tct_out_t result, one per request
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data thresholds
//
// A request takes an accept step, a scan through the id memory (one entry
// read a cycle, registered read, ending at the first match) and an update step.
// Cancel and unknown kinds skip the scan and go straight to the update.
// Reset (rst_n low, synchronous) clears all active and valid bits; no sweep.
// A result waiting on out_stall does not block the next request, but the
// update of that request waits until the output register frees.
module touch_contact_tracker
  import tct_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tct_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tct_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(SLOTS);

  typedef struct packed {
    logic [1:0] ctype;
    logic [7:0] id;
  } key_t;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] start_position;
    logic [31:0] raw_position;
    logic [31:0] raw_start;
    logic [15:0] pressure;
    logic [31:0] down_time;
  } entry_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE} state_t;

  function automatic logic [1:0] classify(input logic [15:0] p, input logic [15:0] fthr,
                                          input logic [15:0] tthr, input logic [15:0] pthr);
    logic [1:0] t;
    if (p >= pthr) t = TYPE_PALM;
    else if (p >= tthr) t = TYPE_THUMB;
    else if (p >= fthr) t = TYPE_FINGER;
    else t = TYPE_NONE;
    return t;
  endfunction

  key_t   key_mem [SLOTS];
  entry_t data_mem [SLOTS];

  state_t            state_r;
  tct_in_t           req_r;
  logic [CNT_W-1:0]  scan_ptr_r;
  logic              chk_vld_r;
  logic [IDX_W-1:0]  chk_idx_r;
  key_t              key_rd_r;
  entry_t            data_rd_r;
  logic              found_r;
  logic [IDX_W-1:0]  hit_idx_r;
  key_t              key_hit_r;
  entry_t            data_hit_r;
  logic [SLOTS-1:0]  active_r;
  logic [SLOTS-1:0]  valid_r;
  logic [15:0]       finger_thr_r;
  logic [15:0]       thumb_thr_r;
  logic [15:0]       palm_thr_r;
  logic              out_valid_r;
  tct_out_t          out_data_r;

  logic        is_down;
  logic        slot_match;
  logic        scan_done;
  logic        out_free;
  logic        mem_we;
  logic [1:0]  type_nxt;
  logic        type_ok;
  logic [31:0] idx_ext;
  key_t        key_nxt;
  entry_t      data_nxt;
  tct_out_t    res_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_down    = (req_r.kind == KIND_DOWN);
  assign slot_match = chk_vld_r && (is_down ? !active_r[chk_idx_r]
                      : (active_r[chk_idx_r] && key_rd_r.id == req_r.contact_id));
  assign scan_done  = (scan_ptr_r == SLOT_CNT) && !chk_vld_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign type_nxt   = classify(req_r.contact_pressure, finger_thr_r, thumb_thr_r, palm_thr_r);
  assign type_ok    = (type_nxt == TYPE_FINGER) || (type_nxt == TYPE_THUMB);
  assign idx_ext    = 32'(hit_idx_r);

  always_comb begin
    key_nxt  = '{ctype: type_nxt, id: req_r.contact_id};
    data_nxt = data_hit_r;
    res_nxt  = '0;
    mem_we   = 1'b0;
    unique case (req_r.kind)
      KIND_DOWN: begin
        data_nxt.position       = {req_r.pos_y, req_r.pos_x};
        data_nxt.start_position = {req_r.pos_y, req_r.pos_x};
        data_nxt.raw_position   = {req_r.raw_y, req_r.raw_x};
        data_nxt.raw_start      = {req_r.raw_y, req_r.raw_x};
        data_nxt.pressure       = req_r.contact_pressure;
        data_nxt.down_time      = req_r.time_now;
        res_nxt.contact_type    = type_nxt;
        res_nxt.contact_valid   = type_ok;
        mem_we                  = found_r;
      end
      KIND_MOTION: begin
        data_nxt.position     = {req_r.pos_y, req_r.pos_x};
        data_nxt.raw_position = {req_r.raw_y, req_r.raw_x};
        key_nxt               = key_hit_r;
        res_nxt.contact_type  = key_hit_r.ctype;
        res_nxt.contact_valid = valid_r[hit_idx_r];
        mem_we                = found_r;
      end
      KIND_PRESSURE: begin
        data_nxt.pressure     = req_r.contact_pressure;
        res_nxt.contact_type  = type_nxt;
        res_nxt.contact_valid = type_ok;
        mem_we                = found_r;
      end
      KIND_UP: begin
        res_nxt.contact_type = key_hit_r.ctype;
      end
      default: ;
    endcase
    if (found_r) begin
      res_nxt.slot_index = idx_ext[3:0];
      res_nxt.hit        = 1'b1;
    end else begin
      res_nxt = '0;
    end
    res_nxt.table_full = is_down && !found_r;
    if (state_r != ST_UPDATE || !out_free) mem_we = 1'b0;
  end

  // id/class memory and payload memory, read during the scan, written on update
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && scan_ptr_r != SLOT_CNT) begin
      key_rd_r  <= key_mem[scan_ptr_r[IDX_W-1:0]];
      data_rd_r <= data_mem[scan_ptr_r[IDX_W-1:0]];
    end
    if (mem_we) begin
      key_mem[hit_idx_r]  <= key_nxt;
      data_mem[hit_idx_r] <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_ptr_r   <= '0;
      chk_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      active_r     <= '0;
      valid_r      <= '0;
      finger_thr_r <= 16'h0000;
      thumb_thr_r  <= 16'hFFFF;
      palm_thr_r   <= 16'hFFFF;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FINGER_THR: finger_thr_r <= cfg_data;
          REG_THUMB_THR:  thumb_thr_r  <= cfg_data;
          REG_PALM_THR:   palm_thr_r   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            req_r      <= in_data;
            scan_ptr_r <= '0;
            chk_vld_r  <= 1'b0;
            found_r    <= 1'b0;
            if (in_data.kind == KIND_DOWN || in_data.kind == KIND_MOTION ||
                in_data.kind == KIND_PRESSURE || in_data.kind == KIND_UP) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_UPDATE;
            end
          end
        end
        ST_SCAN: begin
          chk_vld_r <= (scan_ptr_r != SLOT_CNT);
          chk_idx_r <= scan_ptr_r[IDX_W-1:0];
          if (scan_ptr_r != SLOT_CNT) scan_ptr_r <= scan_ptr_r + 1'b1;
          if (slot_match) begin
            found_r    <= 1'b1;
            hit_idx_r  <= chk_idx_r;
            key_hit_r  <= key_rd_r;
            data_hit_r <= data_rd_r;
            state_r    <= ST_UPDATE;
          end else if (scan_done) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_nxt;
            state_r     <= ST_IDLE;
            if (req_r.kind == KIND_CANCEL) begin
              active_r <= '0;
              valid_r  <= '0;
            end else if (found_r) begin
              case (req_r.kind)
                KIND_DOWN: begin
                  active_r[hit_idx_r] <= 1'b1;
                  valid_r[hit_idx_r]  <= type_ok;
                end
                KIND_PRESSURE: valid_r[hit_idx_r] <= type_ok;
                KIND_UP: begin
                  active_r[hit_idx_r] <= 1'b0;
                  valid_r[hit_idx_r]  <= 1'b0;
                end
                default: ;
              endcase
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/tct_checker.sv */
// Port-level checks for the touch contact tracker, bound to the top level.
module tct_checker
  import tct_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input tct_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> !out_data.hit && out_data.slot_index == 4'd0)
    else $error("table full result carries a slot");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |->
      out_data.slot_index == 4'd0 && out_data.contact_type == TYPE_NONE &&
      !out_data.contact_valid)
    else $error("miss result not cleared");

  a_valid_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.contact_valid |->
      out_data.contact_type == TYPE_FINGER || out_data.contact_type == TYPE_THUMB)
    else $error("valid contact of wrong class");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind touch_contact_tracker tct_checker u_tct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* sim/tb_top.sv */
// Testbench for the touch contact tracker: queued event requests, shadow slot table, scoreboard.
`timescale 1ns / 100ps

module tb_top
  import tct_pkg::*;
();

  localparam int SLOTS = 16;
  localparam int LONG_HOLD = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 4 * (SLOTS + 4);
  localparam int PHASE_ITEMS = 250;
  localparam logic [2:0] KIND_FIRST_SPARE = KIND_CANCEL + 3'd1;
  localparam logic [2:0] KIND_LAST_SPARE = '1;

  typedef struct packed {
    logic        active;
    logic        valid;
    logic [1:0]  ctype;
    logic [7:0]  cid;
    logic [31:0] pos;
    logic [31:0] start_pos;
    logic [31:0] raw_pos;
    logic [31:0] raw_start;
    logic [15:0] pressure;
    logic [31:0] down_time;
  } contact_slot_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  tct_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  tct_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow table and thresholds
  contact_slot_t slots [SLOTS];
  logic [15:0]   finger_thr = 16'd0;
  logic [15:0]   thumb_thr = 16'hFFFF;
  logic [15:0]   palm_thr = 16'hFFFF;

  tct_in_t    pending_events[$];
  tct_out_t   expected_results[$];
  logic [7:0] live_ids[$];
  int         events_queued = 0;
  int         results_seen = 0;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_reqs = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  int         fill_goal = 0;
  logic       in_taken = 1'b0;

  touch_contact_tracker #(.SLOTS(SLOTS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [1:0] pressure_class(input logic [15:0] p);
    if (p >= palm_thr) return TYPE_PALM;
    if (p >= thumb_thr) return TYPE_THUMB;
    if (p >= finger_thr) return TYPE_FINGER;
    return TYPE_NONE;
  endfunction

  function automatic void reclassify(input int s, input logic [15:0] p);
    slots[s].pressure = p;
    slots[s].ctype = pressure_class(p);
    slots[s].valid = (slots[s].ctype == TYPE_FINGER) || (slots[s].ctype == TYPE_THUMB);
  endfunction

  function automatic int find_contact(input logic [7:0] cid);
    for (int s = 0; s < SLOTS; s++) begin
      if (slots[s].active && slots[s].cid == cid) return s;
    end
    return -1;
  endfunction

  function automatic tct_out_t track_event(input tct_in_t ev);
    tct_out_t res;
    int       hit_slot;
    res = '0;
    hit_slot = -1;
    case (ev.kind)
      KIND_DOWN: begin
        for (int s = SLOTS - 1; s >= 0; s--) begin
          if (!slots[s].active) hit_slot = s;
        end
        if (hit_slot < 0) begin
          res.table_full = 1'b1;
        end else begin
          slots[hit_slot].active = 1'b1;
          slots[hit_slot].cid = ev.contact_id;
          slots[hit_slot].pos = {ev.pos_y, ev.pos_x};
          slots[hit_slot].start_pos = {ev.pos_y, ev.pos_x};
          slots[hit_slot].raw_pos = {ev.raw_y, ev.raw_x};
          slots[hit_slot].raw_start = {ev.raw_y, ev.raw_x};
          slots[hit_slot].down_time = ev.time_now;
          reclassify(hit_slot, ev.contact_pressure);
        end
      end
      KIND_MOTION: begin
        hit_slot = find_contact(ev.contact_id);
        if (hit_slot >= 0) begin
          slots[hit_slot].pos = {ev.pos_y, ev.pos_x};
          slots[hit_slot].raw_pos = {ev.raw_y, ev.raw_x};
        end
      end
      KIND_PRESSURE: begin
        hit_slot = find_contact(ev.contact_id);
        if (hit_slot >= 0) reclassify(hit_slot, ev.contact_pressure);
      end
      KIND_UP: begin
        hit_slot = find_contact(ev.contact_id);
        if (hit_slot >= 0) begin
          slots[hit_slot].active = 1'b0;
          slots[hit_slot].valid = 1'b0;
        end
      end
      KIND_CANCEL: begin
        for (int s = 0; s < SLOTS; s++) begin
          slots[s].active = 1'b0;
          slots[s].valid = 1'b0;
        end
      end
      default: ;
    endcase
    if (hit_slot >= 0) begin
      res.slot_index = 4'(hit_slot);
      res.hit = 1'b1;
      res.contact_type = slots[hit_slot].ctype;
      res.contact_valid = slots[hit_slot].valid;
    end
    return res;
  endfunction

  task automatic note_fault(input string what, input tct_out_t want, input tct_out_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected idx=%0d hit=%0b type=%0d valid=%0b full=%0b,",
               $time, what, want.slot_index, want.hit, want.contact_type,
               want.contact_valid, want.table_full);
      $display("  got idx=%0d hit=%0b type=%0d valid=%0b full=%0b",
               got.slot_index, got.hit, got.contact_type, got.contact_valid,
               got.table_full);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_events.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_data <= pending_events.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure, with the occasional long hold-off
  always @(negedge clk) begin
    if (hold_left == 0 && hold_reqs != holds_served) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    tct_out_t want;
    logic     progress;
    in_taken = 1'b0;
    if (rst_n) begin
      progress = cfg_valid && cfg_ready;
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        results_seen++;
        if (expected_results.size() == 0) begin
          note_fault("unexpected result", '0, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.slot_index !== want.slot_index || out_data.hit !== want.hit ||
              out_data.contact_type !== want.contact_type ||
              out_data.contact_valid !== want.contact_valid ||
              out_data.table_full !== want.table_full) begin
            note_fault("result mismatch", want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        progress = 1'b1;
        in_taken = 1'b1;
        expected_results = {expected_results, track_event(in_data)};
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FINGER_THR: finger_thr = val;
      REG_THUMB_THR:  thumb_thr = val;
      REG_PALM_THR:   palm_thr = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results_seen != events_queued) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_pressure();
    case ($urandom_range(10, 0))
      0: return finger_thr;
      1: return finger_thr - 16'd1;
      2: return thumb_thr;
      3: return thumb_thr - 16'd1;
      4: return palm_thr;
      5: return palm_thr - 16'd1;
      6: return 16'h0000;
      7: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic tct_in_t rand_event(input logic [2:0] kind, input logic [7:0] cid);
    tct_in_t ev;
    ev.kind = kind;
    ev.contact_id = cid;
    ev.pos_x = 16'($urandom());
    ev.pos_y = 16'($urandom());
    ev.raw_x = 16'($urandom());
    ev.raw_y = 16'($urandom());
    ev.contact_pressure = pick_pressure();
    ev.time_now = $urandom();
    return ev;
  endfunction

  function automatic logic [7:0] pick_live();
    return live_ids[$urandom_range(live_ids.size() - 1, 0)];
  endfunction

  function automatic logic [2:0] pick_tracked_kind();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 45) return KIND_MOTION;
    if (roll < 80) return KIND_PRESSURE;
    return KIND_UP;
  endfunction

  task automatic queue_event(input tct_in_t ev);
    logic removed;
    removed = 1'b0;
    case (ev.kind)
      KIND_DOWN: if (live_ids.size() < SLOTS) live_ids = {live_ids, ev.contact_id};
      KIND_UP: begin
        for (int i = 0; i < live_ids.size(); i++) begin
          if (!removed && live_ids[i] == ev.contact_id) begin
            live_ids.delete(i);
            removed = 1'b1;
          end
        end
      end
      KIND_CANCEL: live_ids.delete();
      default: ;
    endcase
    pending_events = {pending_events, ev};
    events_queued++;
  endtask

  // mostly down/move/press/up sequences on live contacts, plus noise
  task automatic queue_random(input int count);
    tct_in_t    ev;
    int         roll;
    logic       want_down;
    logic [7:0] cid;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) fill_goal = $urandom_range(SLOTS + 3, 0);
      roll = $urandom_range(99, 0);
      want_down = (live_ids.size() < fill_goal) ? (roll < 60) : (roll < 8);
      if (want_down) begin
        cid = (live_ids.size() != 0 && $urandom_range(4, 0) == 0) ? pick_live()
                                                                 : 8'($urandom());
        ev = rand_event(KIND_DOWN, cid);
      end else if (roll < 90 && live_ids.size() != 0) begin
        ev = rand_event(pick_tracked_kind(), pick_live());
      end else if (roll < 96) begin
        ev = rand_event(pick_tracked_kind(), 8'($urandom()));
      end else if (roll < 99) begin
        ev = rand_event(3'($urandom_range(KIND_LAST_SPARE, KIND_FIRST_SPARE)), 8'($urandom()));
      end else begin
        ev = rand_event(KIND_CANCEL, 8'($urandom()));
      end
      queue_event(ev);
    end
  endtask

  task automatic run_phase(input logic [15:0] f_thr, input logic [15:0] t_thr,
                           input logic [15:0] p_thr, input int send_pct, input int recv_pct,
                           input logic long_hold, input logic mid_pause);
    wait_drained();
    write_threshold(REG_FINGER_THR, f_thr);
    write_threshold(REG_THUMB_THR, t_thr);
    write_threshold(REG_PALM_THR, p_thr);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (mid_pause) begin
      queue_random(PHASE_ITEMS / 2);
      wait_drained();
      queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    end else begin
      queue_random(PHASE_ITEMS);
    end
    if (long_hold) hold_reqs++;
  endtask

  initial begin
    tct_in_t ev;
    foreach (slots[s]) slots[s] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 49;
    write_threshold(REG_FINGER_THR, 16'd100);
    write_threshold(REG_THUMB_THR, 16'd1000);
    write_threshold(REG_PALM_THR, 16'd40000);

    queue_event(rand_event(KIND_CANCEL, 8'h00));
    queue_event(rand_event(KIND_MOTION, 8'hFF));
    ev = '0;
    ev.kind = KIND_DOWN;
    queue_event(ev);
    ev = '1;
    ev.kind = KIND_DOWN;
    queue_event(ev);
    // duplicate id: lowest active slot wins
    ev = rand_event(KIND_DOWN, 8'h00);
    ev.contact_pressure = 16'd500;
    queue_event(ev);
    queue_event(rand_event(KIND_MOTION, 8'h00));
    ev = rand_event(KIND_PRESSURE, 8'h00);
    ev.contact_pressure = 16'd2000;
    queue_event(ev);
    queue_event(rand_event(KIND_UP, 8'h00));
    queue_event(rand_event(KIND_MOTION, 8'h00));
    queue_event(rand_event(KIND_FIRST_SPARE, 8'h01));
    queue_event(rand_event(KIND_LAST_SPARE, 8'h02));
    // fill the table, then one request too many
    repeat (SLOTS - 1) queue_event(rand_event(KIND_DOWN, 8'($urandom())));

    run_phase(16'd100, 16'd1000, 16'd40000, 35, 49, 1'b1, 1'b0);
    run_phase(16'h0000, 16'hFFFF, 16'hFFFF, 35, 49, 1'b0, 1'b1);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 49, 35, 1'b1, 1'b0);
    run_phase(16'h0000, 16'h0000, 16'h0000, 49, 35, 1'b0, 1'b0);
    run_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 0, 0, 1'b0, 1'b0);
    run_phase(16'd50000, 16'd20000, 16'd60000, 0, 0, 1'b0, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
